FILE: hdl/wpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants for the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

    // Pattern storage depth and derived widths
    localparam int MAX_PATTERN = 32;
    localparam int ROW_W       = MAX_PATTERN + 1;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEVELS      = $clog2(MAX_PATTERN + 1);

    // Wildcard characters
    localparam logic [7:0] STAR_CHAR  = 8'h2A;
    localparam logic [7:0] QMARK_CHAR = 8'h3F;

    // Request opcodes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_TEXT   = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_code;
    } req_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } res_t;

    // Classified command handed from front to back
    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_TEXT   = 2'd1,
        KIND_END    = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_code;
    } cmd_t;

endpackage

FILE: hdl/wpm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_front
// Accepts requests, decodes the opcode and queues commands for the back end.
// ----------------------------------------------------------------------------
module wpm_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  wpm_pkg::req_t req_data,
    output logic          cmd_valid,
    input  logic          cmd_take,
    output wpm_pkg::cmd_t cmd_data
);

    localparam int DEPTH = 2;

    wpm_pkg::cmd_t queue_reg [DEPTH];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    logic          accept;
    logic          push;
    logic          pop;
    logic          known_op;
    wpm_pkg::cmd_t cmd_in;

    // Classify; the unused opcode is accepted and dropped
    always_comb
    begin
        known_op         = 1'b1;
        cmd_in.char_code = req_data.char_code;
        cmd_in.kind      = wpm_pkg::KIND_APPEND;
        case (req_data.opcode)
            wpm_pkg::OP_APPEND: cmd_in.kind = wpm_pkg::KIND_APPEND;
            wpm_pkg::OP_TEXT:   cmd_in.kind = wpm_pkg::KIND_TEXT;
            wpm_pkg::OP_END:    cmd_in.kind = wpm_pkg::KIND_END;
            default:            known_op    = 1'b0;
        endcase
    end

    assign req_stall = (count_reg == 2'(DEPTH));
    assign accept    = req_valid && !req_stall;
    assign push      = accept && known_op;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_valid && cmd_take;
    assign cmd_data  = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

FILE: hdl/wpm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_back
// Holds the pattern and prefix match row, executes commands, drives results.
// ----------------------------------------------------------------------------
module wpm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_take,
    input  wpm_pkg::cmd_t cmd_data,
    output logic          res_valid,
    input  logic          res_stall,
    output wpm_pkg::res_t res_data
);

    localparam int N = wpm_pkg::MAX_PATTERN;

    logic [7:0]                   store_reg [N];
    logic [wpm_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [wpm_pkg::ROW_W-1:0]    row_reg, row_next;
    logic                         ovf_reg, ovf_next;
    logic                         res_valid_reg, res_valid_next;
    wpm_pkg::res_t                res_reg, res_next;

    logic [N-1:0]                 in_pat;
    logic [N-1:0]                 is_star;
    logic [N-1:0]                 one_hit;
    logic [wpm_pkg::LEVELS:0][wpm_pkg::ROW_W-1:0] g_lvl;
    logic [wpm_pkg::LEVELS:0][wpm_pkg::ROW_W-1:0] p_lvl;
    logic [wpm_pkg::ROW_W-1:0]    cur;
    logic [wpm_pkg::ROW_W-1:0]    nxt;
    logic                         at_end;
    logic                         text_star;
    logic                         store_we;
    logic                         hit;
    logic                         take;

    assign at_end    = (cmd_data.kind == wpm_pkg::KIND_END);
    assign text_star = (cmd_data.char_code == wpm_pkg::STAR_CHAR);

    // Hold an end command while an unread result blocks the output register
    assign take     = cmd_valid && (!at_end || !res_valid_reg || !res_stall);
    assign cmd_take = take;

    // Per-entry compare against the current byte
    always_comb
    begin
        for (int j = 0; j < N; j++)
        begin
            in_pat[j]  = (wpm_pkg::LEN_W'(j) < len_reg);
            is_star[j] = (store_reg[j] == wpm_pkg::STAR_CHAR);
            one_hit[j] = (store_reg[j] == cmd_data.char_code) ||
                         (store_reg[j] == wpm_pkg::QMARK_CHAR);
        end
    end

    // Spread the row across runs of stars with a parallel prefix network
    always_comb
    begin
        g_lvl[0]    = row_reg;
        p_lvl[0]    = '0;
        for (int j = 1; j <= N; j++)
        begin
            p_lvl[0][j] = is_star[j-1] && in_pat[j-1] && (at_end || !text_star);
        end
        for (int l = 0; l < wpm_pkg::LEVELS; l++)
        begin
            for (int j = 0; j <= N; j++)
            begin
                if (j >= (1 << l))
                begin
                    g_lvl[l+1][j] = g_lvl[l][j] || (p_lvl[l][j] && g_lvl[l][j-(1<<l)]);
                    p_lvl[l+1][j] = p_lvl[l][j] && p_lvl[l][j-(1<<l)];
                end
                else
                begin
                    g_lvl[l+1][j] = g_lvl[l][j];
                    p_lvl[l+1][j] = p_lvl[l][j];
                end
            end
        end
        cur = g_lvl[wpm_pkg::LEVELS];
    end

    // Advance the row by one text byte; an exact or '?' hit wins over a star
    always_comb
    begin
        nxt = '0;
        for (int j = 0; j < N; j++)
        begin
            if (cur[j] && in_pat[j])
            begin
                if (one_hit[j])
                begin
                    nxt[j+1] = 1'b1;
                end
                else if (is_star[j])
                begin
                    nxt[j] = 1'b1;
                end
            end
        end
    end

    assign hit = cur[len_reg] && !ovf_reg;

    always_comb
    begin
        len_next       = len_reg;
        row_next       = row_reg;
        ovf_next       = ovf_reg;
        store_we       = 1'b0;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        if (take)
        begin
            case (cmd_data.kind)
                wpm_pkg::KIND_APPEND:
                begin
                    if (len_reg < wpm_pkg::LEN_W'(N))
                    begin
                        store_we = 1'b1;
                        len_next = len_reg + wpm_pkg::LEN_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                wpm_pkg::KIND_TEXT:
                begin
                    row_next = nxt;
                end
                wpm_pkg::KIND_END:
                begin
                    res_next.matched          = hit;
                    res_next.pattern_overflow = ovf_reg;
                    res_valid_next            = 1'b1;
                    row_next                  = wpm_pkg::ROW_W'(1);
                    len_next                  = '0;
                    ovf_next                  = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            row_reg       <= wpm_pkg::ROW_W'(1);
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            row_reg       <= row_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (store_we)
        begin
            store_reg[len_reg[wpm_pkg::IDX_W-1:0]] <= cmd_data.char_code;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

FILE: hdl/wildcard_pattern_matcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_unit
// Glob matcher: '?' takes one byte, '*' takes any run. Pattern bytes load
// first, text bytes stream through a prefix match row, an end request reports.
// ----------------------------------------------------------------------------
//
//  channel | signals                       | payload fields
//  --------+-------------------------------+-------------------------------
//  request | req_valid, req_stall, req_data| opcode, char_code
//  result  | res_valid, res_stall, res_data| matched, pattern_overflow
//
// One request per cycle is sustained while req_stall is low; the next prefix row
// is computed combinationally through a parallel prefix network over the stored pattern.
// res_valid rises once its end request has passed through the queue and then into
// the output register; other requests give none.
// Reset empties the queue and pattern, sets only row bit zero, clears overflow.
// Stall on the result side holds only end requests; the two-entry queue keeps
// accepting until full, which raises req_stall.
//
module wildcard_pattern_matcher_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  wpm_pkg::req_t req_data,
    output logic          res_valid,
    input  logic          res_stall,
    output wpm_pkg::res_t res_data
);

    logic          cmd_valid;
    logic          cmd_take;
    wpm_pkg::cmd_t cmd_data;

    // Front end: accept, decode, queue
    wpm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd_data  (cmd_data)
    );

    // Back end: pattern store, match row, result register
    wpm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule
